// File: hw/rtl/binary_code_coverage_checker_core_defines.svh
// Assertion macros for the binary code coverage checker core.
// Used by the top level; relies on clk_i and rst_ni being in scope.
`ifndef BINARY_CODE_COVERAGE_CHECKER_CORE_DEFINES_SVH
`define BINARY_CODE_COVERAGE_CHECKER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BCCC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BCCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bccc_pkg.sv
// Shared types and constants of the binary code coverage checker.
// No dependencies; the front, lookup, output buffer and top-level RTL files import this package.
`default_nettype none

package bccc_pkg;

  // Default longest code length; sets the seen-map depth of 2^N entries.
  localparam int DEF_MAX_CODE_LEN = 16;

  // Fixed field widths.
  localparam int CODE_LEN_W  = 5;
  localparam int COUNT_OUT_W = 17;

  // Width of the string tag stored in each seen-map entry.
  localparam int EPOCH_W = 8;

  // Output buffer depth and the width of its fill count.
  localparam int OUT_DEPTH = 3;
  localparam int FIFO_CW   = $clog2(OUT_DEPTH + 1);
  localparam int FIFO_PW   = $clog2(OUT_DEPTH);

  // Payload of an input item.
  typedef struct packed {
    logic bit_value;
    logic last_bit;
  } in_item_t;

  // Payload of a result item.
  typedef struct packed {
    logic                   all_present;
    logic [COUNT_OUT_W-1:0] distinct_count;
    logic                   string_done;
  } out_item_t;

  // Payload of a configuration write.
  typedef struct packed {
    logic [CODE_LEN_W-1:0] code_len;
  } cfg_item_t;

  // Control of one lookup request from the front stage to the lookup stage.
  typedef struct packed {
    logic                  vld;
    logic                  lookup;
    logic                  last;
    logic                  wrap;
    logic [CODE_LEN_W-1:0] k;
    logic [EPOCH_W-1:0]    epoch;
  } req_ctl_t;

  // Status of the lookup stage seen by the front stage.
  typedef struct packed {
    logic s1_vld;
    logic busy;
  } lkp_status_t;

  // Lookup stage control states.
  typedef enum logic {
    LKP_SWEEP,
    LKP_RUN
  } lkp_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/bccc_stream_if.sv
// Valid/ready channel carrying one item payload of a given type.
// Standalone; the payload types come from bccc_pkg at the instance.
`default_nettype none

interface bccc_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bccc_front.sv
// Front stage: code length register, bit window, bit counter and string tag.
// Depends on bccc_pkg and bccc_stream_if; issues the seen-map read address.
`default_nettype none

module bccc_front import bccc_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  bccc_stream_if.sink             in_ch,
  bccc_stream_if.sink             cfg_ch,
  input  lkp_status_t             lkp_st_i,
  input  wire [FIFO_CW-1:0]       fifo_cnt_i,
  output req_ctl_t                req_o,
  output logic [MAX_CODE_LEN-1:0] code_o
);

  localparam int KW = $clog2(MAX_CODE_LEN + 1);

  logic [CODE_LEN_W-1:0]   code_len_q;
  logic [MAX_CODE_LEN-1:0] win_q, win_d;
  logic [KW-1:0]           bits_seen_q, bits_seen_d;
  logic [EPOCH_W-1:0]      epoch_q, epoch_d;

  logic                    accept;
  logic                    wrap;
  logic [CODE_LEN_W-1:0]   k;
  logic [MAX_CODE_LEN:0]   win_ext;
  logic [MAX_CODE_LEN-1:0] win_next;
  logic [MAX_CODE_LEN-1:0] code_mask;
  logic [KW-1:0]           bits_next;
  logic [FIFO_CW:0]        in_flight;

  // Configuration writes are always taken.
  assign cfg_ch.ready = 1'b1;

  // Take an item unless the map is being swept or the output buffer could overflow.
  assign in_flight   = {1'b0, fifo_cnt_i} + {{FIFO_CW{1'b0}}, lkp_st_i.s1_vld};
  assign in_ch.ready = !lkp_st_i.busy && (in_flight < (FIFO_CW + 1)'(OUT_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  // Effective code length: zero acts as one, large values clip to the maximum.
  always_comb begin
    if (code_len_q == '0) begin
      k = CODE_LEN_W'(1);
    end else if (code_len_q > CODE_LEN_W'(MAX_CODE_LEN)) begin
      k = CODE_LEN_W'(MAX_CODE_LEN);
    end else begin
      k = code_len_q;
    end
  end

  // Shift the new bit in and mask the window down to k bits.
  assign win_ext   = {win_q, in_ch.payload.bit_value};
  assign win_next  = win_ext[MAX_CODE_LEN-1:0];
  assign code_mask = ~({MAX_CODE_LEN{1'b1}} << k);
  assign bits_next = (bits_seen_q < KW'(MAX_CODE_LEN)) ? bits_seen_q + KW'(1) : bits_seen_q;
  assign wrap      = in_ch.payload.last_bit && (epoch_q == {EPOCH_W{1'b1}});

  // Lookup request for the item taken in this cycle.
  always_comb begin
    req_o.vld    = accept;
    req_o.lookup = (CODE_LEN_W'(bits_next) >= k);
    req_o.last   = in_ch.payload.last_bit;
    req_o.wrap   = wrap;
    req_o.k      = k;
    req_o.epoch  = epoch_q;
    code_o       = win_next & code_mask;
  end

  // Window, counter and tag advance; the last bit of a string starts a new tag.
  always_comb begin
    win_d       = win_q;
    bits_seen_d = bits_seen_q;
    epoch_d     = epoch_q;
    if (accept) begin
      if (in_ch.payload.last_bit) begin
        win_d       = '0;
        bits_seen_d = '0;
        epoch_d     = wrap ? EPOCH_W'(1) : epoch_q + EPOCH_W'(1);
      end else begin
        win_d       = win_next;
        bits_seen_d = bits_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_len_q  <= CODE_LEN_W'(1);
      win_q       <= '0;
      bits_seen_q <= '0;
      epoch_q     <= EPOCH_W'(1);
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        code_len_q <= cfg_ch.payload.code_len;
      end
      win_q       <= win_d;
      bits_seen_q <= bits_seen_d;
      epoch_q     <= epoch_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bccc_lookup.sv
// Lookup stage: tagged seen-map memory, read-modify-write with forwarding,
// clearing sweep and distinct-code count. Depends on bccc_pkg.
`default_nettype none

module bccc_lookup import bccc_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  req_ctl_t                req_i,
  input  wire [MAX_CODE_LEN-1:0]  code_i,
  output lkp_status_t             lkp_st_o,
  output logic                    push_o,
  output out_item_t               result_o
);

  localparam int ADDR_W = MAX_CODE_LEN;
  localparam int DEPTH  = 1 << MAX_CODE_LEN;
  localparam int CNT_W  = MAX_CODE_LEN + 1;

  // One tag per code; an entry counts as seen when its tag matches the string's.
  logic [EPOCH_W-1:0] seen_mem [DEPTH];

  lkp_state_e         state_q, state_d;
  logic [ADDR_W-1:0]  sweep_addr_q, sweep_addr_d;
  req_ctl_t           s1_q;
  logic [ADDR_W-1:0]  s1_code_q;
  logic               fwd_q, fwd_d;
  logic [EPOCH_W-1:0] rdata_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic               seen;
  logic               is_new;
  logic [CNT_W-1:0]   cnt_cur;
  logic [CNT_W-1:0]   full;
  logic               we;
  logic               sweep_we;
  logic [ADDR_W-1:0]  waddr;
  logic [EPOCH_W-1:0] wdata;

  // Second stage: decide whether the code is new in this string.
  assign seen    = (rdata_q == s1_q.epoch) || fwd_q;
  assign is_new  = s1_q.vld && s1_q.lookup && !seen;
  assign cnt_cur = cnt_q + CNT_W'(is_new);
  assign full    = CNT_W'(1) << s1_q.k;

  // Write port: item updates first, sweep only while the stage is empty.
  always_comb begin
    sweep_we = (state_q == LKP_SWEEP) && !s1_q.vld;
    we       = is_new || sweep_we;
    if (is_new) begin
      waddr = s1_code_q;
      wdata = s1_q.epoch;
    end else begin
      waddr = sweep_addr_q;
      wdata = '0;
    end
  end

  // A read in the same cycle as a write to that entry misses the new tag.
  assign fwd_d = we && (waddr == code_i) && (wdata == req_i.epoch);

  // Sweep control: reset and every tag wrap clear all entries.
  always_comb begin
    state_d      = state_q;
    sweep_addr_d = sweep_addr_q;
    case (state_q)
      LKP_RUN: begin
        if (req_i.vld && req_i.wrap) begin
          state_d = LKP_SWEEP;
        end
      end
      LKP_SWEEP: begin
        if (sweep_we) begin
          sweep_addr_d = sweep_addr_q + ADDR_W'(1);
          if (sweep_addr_q == {ADDR_W{1'b1}}) begin
            state_d = LKP_RUN;
          end
        end
      end
      default: begin
        state_d = LKP_SWEEP;
      end
    endcase
  end

  // Running count; the last bit of a string clears it.
  always_comb begin
    cnt_d = cnt_q;
    if (s1_q.vld) begin
      cnt_d = s1_q.last ? '0 : cnt_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= LKP_SWEEP;
      sweep_addr_q <= '0;
      s1_q         <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      sweep_addr_q <= sweep_addr_d;
      s1_q         <= req_i;
      cnt_q        <= cnt_d;
    end
  end

  // Payload of the second stage.
  always_ff @(posedge clk_i) begin
    s1_code_q <= code_i;
    fwd_q     <= fwd_d;
  end

  // Seen-map memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      seen_mem[waddr] <= wdata;
    end
    rdata_q <= seen_mem[code_i];
  end

  assign lkp_st_o.s1_vld = s1_q.vld;
  assign lkp_st_o.busy   = (state_q == LKP_SWEEP);

  assign push_o                  = s1_q.vld;
  assign result_o.all_present    = (cnt_cur >= full);
  assign result_o.distinct_count = COUNT_OUT_W'(cnt_cur);
  assign result_o.string_done    = s1_q.last;

endmodule

`default_nettype wire

// File: hw/rtl/bccc_out_fifo.sv
// Output buffer of result items, a few entries deep, driving the result channel.
// Depends on bccc_pkg and bccc_stream_if.
`default_nettype none

module bccc_out_fifo import bccc_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  out_item_t          push_data_i,
  bccc_stream_if.source      out_ch,
  output logic [FIFO_CW-1:0] fifo_cnt_o
);

  out_item_t          buf_q [OUT_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic               pop;

  assign out_ch.valid   = (cnt_q != '0);
  assign out_ch.payload = buf_q[rd_ptr_q];
  assign pop            = out_ch.valid && out_ch.ready;
  assign fifo_cnt_o     = cnt_q;

  // Pointer and count update with wrap at the buffer depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_PW'(1);
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + FIFO_CW'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/binary_code_coverage_checker_core.sv
// Binary code coverage checker: tells whether a bit string holds every k-bit code.
// Channels: in_ch takes one bit of the string per item, with last_bit marking its
// final bit; out_ch gives one result per input item: the distinct code count so
// far, whether all 2^k codes have appeared, and string_done echoing last_bit.
// cfg_ch writes the code length k; write it only while no item is in flight.
// Throughput is one item per cycle unless a sweep runs or the output buffer holds back
// input: each bit costs one read-modify-write of the seen map, a memory with a registered
// read and forwarding between back-to-back items. Results pass the lookup stage register and the output buffer.
// After reset all 2^MAX_CODE_LEN seen-map entries (65536 at the default) are swept
// clear with in_ch.ready low; configuration writes are taken meanwhile.
// Each string gets a fresh 8-bit tag instead of a clear; after every 255 strings
// the tags wrap and the same sweep runs again once the last bit is taken.
// A three-entry output buffer absorbs stalls; when the receiver holds off,
// in_ch.ready drops as soon as the buffer could fill.
// Depends on bccc_pkg, bccc_stream_if, bccc_front, bccc_lookup, bccc_out_fifo and the defines header.
`default_nettype none
`include "binary_code_coverage_checker_core_defines.svh"

module binary_code_coverage_checker_core import bccc_pkg::*; #(
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  bccc_stream_if.sink   in_ch,
  bccc_stream_if.source out_ch,
  bccc_stream_if.sink   cfg_ch
);

  req_ctl_t                req;
  logic [MAX_CODE_LEN-1:0] code;
  lkp_status_t             lkp_st;
  logic                    push;
  out_item_t               result;
  logic [FIFO_CW-1:0]      fifo_cnt;
  logic                    in_accept;
  logic                    out_pop;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign out_pop   = out_ch.valid && out_ch.ready;

  // Window, configuration and request generation.
  bccc_front #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .lkp_st_i   (lkp_st),
    .fifo_cnt_i (fifo_cnt),
    .req_o      (req),
    .code_o     (code)
  );

  // Seen-map lookup and count.
  bccc_lookup #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_lookup (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .code_i   (code),
    .lkp_st_o (lkp_st),
    .push_o   (push),
    .result_o (result)
  );

  // Result buffer.
  bccc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (result),
    .out_ch      (out_ch),
    .fifo_cnt_o  (fifo_cnt)
  );

  // The input credit check must keep the output buffer from overflowing.
  `BCCC_ASSERT_NOW(a_fifo_room, push && !out_pop, fifo_cnt != FIFO_CW'(OUT_DEPTH), "result buffer overflow")

  // Every taken item reaches the lookup stage in the next cycle.
  `BCCC_ASSERT_NEXT(a_item_in_lookup, in_accept, lkp_st.s1_vld, "taken item missing in lookup stage")

  // A sweep after reset only starts right after a string's last bit was taken.
  `BCCC_ASSERT_NOW(a_sweep_after_last, $rose(lkp_st.busy), $past(in_accept && in_ch.payload.last_bit), "sweep without string end")

endmodule

`default_nettype wire

// File: test/tb_binary_code_coverage_checker_core.sv
// Testbench for binary_code_coverage_checker_core: streams bit strings through in_ch and
// checks every result on out_ch against a behavioral tally of distinct k-bit codes.
// Depends on bccc_pkg, bccc_stream_if and the core RTL.
`default_nettype none

module tb_binary_code_coverage_checker_core;
  import bccc_pkg::*;

  localparam int MAX_K       = DEF_MAX_CODE_LEN;
  localparam int QUIET_LIMIT = 400000;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 24;

  // Tracks the codes seen in the current string and queues the results they imply.
  class code_tally;
    logic [CODE_LEN_W-1:0] code_len;
    int unsigned           window;
    int unsigned           bits_seen;
    int unsigned           n_codes;
    bit                    seen[int unsigned];
    out_item_t             tallies_due[$];
    int unsigned           errors;

    function new();
      code_len = 1;
      errors   = 0;
      clear_string();
    endfunction

    function void clear_string();
      window    = 0;
      bits_seen = 0;
      n_codes   = 0;
      seen.delete();
    endfunction

    // Updates the window and seen set for one accepted item and queues its result.
    function void absorb_bit(in_item_t it);
      int unsigned k;
      int unsigned code;
      out_item_t   t;
      k = code_len;
      if (k == 0) begin
        k = 1;
      end else if (k > MAX_K) begin
        k = MAX_K;
      end
      window = ((window << 1) | it.bit_value) & ((1 << MAX_K) - 1);
      if (bits_seen < MAX_K) bits_seen++;
      if (bits_seen >= k) begin
        code = window & ((1 << k) - 1);
        if (!seen.exists(code)) begin
          seen[code] = 1'b1;
          n_codes++;
        end
      end
      t.all_present    = (n_codes >= (1 << k));
      t.distinct_count = n_codes[COUNT_OUT_W-1:0];
      t.string_done    = it.last_bit;
      tallies_due.insert(tallies_due.size(), t);
      if (it.last_bit) clear_string();
    endfunction

    // Compares one result with the oldest queued one, field by field.
    function void compare_tally(out_item_t got);
      out_item_t want;
      if (tallies_due.size() == 0) begin
        $error("result item with nothing outstanding: distinct_count %0d", got.distinct_count);
        errors++;
        return;
      end
      want = tallies_due.pop_front();
      if (got.all_present !== want.all_present) begin
        $error("all_present expected %0d actual %0d", want.all_present, got.all_present);
        errors++;
      end
      if (got.distinct_count !== want.distinct_count) begin
        $error("distinct_count expected %0d actual %0d",
               want.distinct_count, got.distinct_count);
        errors++;
      end
      if (got.string_done !== want.string_done) begin
        $error("string_done expected %0d actual %0d", want.string_done, got.string_done);
        errors++;
      end
    endfunction

    function int pending();
      return tallies_due.size();
    endfunction
  endclass

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet;
  bit          timed_out;
  code_tally   tally;
  in_item_t    bits_q[$];

  bccc_stream_if #(.item_t(in_item_t))  in_ch();
  bccc_stream_if #(.item_t(out_item_t)) out_ch();
  bccc_stream_if #(.item_t(cfg_item_t)) cfg_ch();

  binary_code_coverage_checker_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each accepted item, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) tally.compare_tally(out_ch.payload);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic int unsigned clamp_k(logic [CODE_LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_K) return MAX_K;
    return len;
  endfunction

  function automatic void add_bit(bit b, bit l);
    in_item_t it;
    it.bit_value = b;
    it.last_bit  = l;
    bits_q.insert(bits_q.size(), it);
  endfunction

  function automatic void add_random(int unsigned n);
    for (int i = 0; i < n; i++) add_bit(1'($urandom_range(1)), 1'b0);
  endfunction

  function automatic void end_string();
    bits_q[bits_q.size()-1].last_bit = 1'b1;
  endfunction

  // Greedy de Bruijn walk: k copies of a random start bit, then prefer the other bit
  // whenever that window is new. This visits every k-bit code exactly once.
  function automatic void add_debruijn(int unsigned k);
    int unsigned mask;
    int unsigned w;
    int unsigned code;
    bit          s;
    bit          b;
    bit          done;
    bit          used[int unsigned];
    s    = 1'($urandom_range(1));
    mask = (1 << k) - 1;
    w    = s ? mask : 0;
    done = 1'b0;
    used[w] = 1'b1;
    for (int i = 0; i < k; i++) add_bit(s, 1'b0);
    while (!done) begin
      b    = !s;
      code = ((w << 1) | b) & mask;
      if (used.exists(code)) begin
        b    = s;
        code = ((w << 1) | b) & mask;
      end
      if (used.exists(code)) begin
        done = 1'b1;
      end else begin
        used[code] = 1'b1;
        w = code;
        add_bit(b, 1'b0);
      end
    end
  endfunction

  // Half the strings give complete coverage where k is small, the rest are random and short strings.
  // Half the time the final string stays open, so k changes in the middle of it.
  function automatic void build_phase(logic [CODE_LEN_W-1:0] len, int unsigned n);
    int unsigned k;
    int unsigned pick;
    k = clamp_k(len);
    while (bits_q.size() < n) begin
      pick = $urandom_range(9);
      if (pick < 5 && k <= 5) begin
        add_random($urandom_range(0, 3));
        add_debruijn(k);
      end else if (pick < 8 || k == 1) begin
        add_random($urandom_range(1, 48));
      end else begin
        add_random($urandom_range(1, k - 1));
      end
      end_string();
    end
    if ($urandom_range(1)) bits_q[bits_q.size()-1].last_bit = 1'b0;
  endfunction

  task automatic write_code_len(logic [CODE_LEN_W-1:0] len);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= '{code_len: len};
    do @(posedge clk_i); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid   <= 1'b0;
    tally.code_len = len;
  endtask

  // Offers one item, sometimes after a random gap, and holds it until it is taken.
  task automatic push_bit(in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    tally.absorb_bit(it);
  endtask

  task automatic send_queued();
    while (bits_q.size() != 0) push_bit(bits_q.pop_front());
    in_ch.valid <= 1'b0;
  endtask

  // Wait for every outstanding result, then let the pipeline drain.
  task automatic settle();
    while (tally.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_checks();
    logic [CODE_LEN_W-1:0] lens[PHASES];
    int unsigned           mode;
    lens = '{5'd2, 5'd1, 5'd3, 5'd4, 5'd0, 5'd5, 5'd16, 5'd2, 5'd31, 5'd3, 5'd17, 5'd1};
    idle_pct  = 0;
    stall_pct = 0;

    // Reset code length of one: a single bit, then both codes.
    add_bit(1'b0, 1'b1);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b1);
    send_queued();
    settle();

    // Code length zero behaves as one.
    write_code_len(5'd0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b1);
    send_queued();
    settle();

    // k of three: a string shorter than k, then one holding all eight codes.
    write_code_len(5'd3);
    add_bit(1'b1, 1'b0);
    add_bit(1'b0, 1'b1);
    add_debruijn(3);
    end_string();
    send_queued();
    settle();

    // Oversized code length is held to the maximum.
    write_code_len(5'd31);
    add_bit(1'b0, 1'b0);
    add_bit(1'b1, 1'b0);
    add_bit(1'b1, 1'b1);
    send_queued();
    settle();

    // Random phases, cycling through the idle and stall patterns.
    for (int p = 0; p < PHASES; p++) begin
      mode      = p % 4;
      idle_pct  = (mode == 1) ? 84 : (mode == 3) ? 22 : 0;
      stall_pct = (mode == 2) ? 84 : (mode == 3) ? 22 : 0;
      write_code_len(lens[p]);
      build_phase(lens[p], PHASE_ITEMS);
      send_queued();
      settle();
    end
  endtask

  initial begin
    tally          = new();
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready   = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    timed_out      = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      run_checks();
      begin
        // Give up after a long stretch with no handshake on any channel.
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
          @(posedge clk_i);
          if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
              (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
              (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
            quiet = 0;
          end else begin
            quiet++;
          end
        end
        timed_out = 1'b1;
      end
    join_any
    if (!timed_out && tally.errors == 0) begin
      $display("[binary_code_coverage_checker_core] OK");
    end else begin
      $display("[binary_code_coverage_checker_core] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+hw/rtl
hw/rtl/bccc_pkg.sv
hw/rtl/bccc_stream_if.sv
hw/rtl/bccc_front.sv
hw/rtl/bccc_lookup.sv
hw/rtl/bccc_out_fifo.sv
hw/rtl/binary_code_coverage_checker_core.sv
test/tb_binary_code_coverage_checker_core.sv
